@@ design/psvb_pkg.sv @@
// Shared types, constants and elaboration-time tables for the sine voice bank.
// Holds the tuning table and the quarter-wave sine table builders; depends on nothing.
package psvb_pkg;

  localparam int NUM_VOICES       = 128;
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam int ADDR_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PHASE_W    = 32;
  localparam int LEVEL_W    = 16;
  localparam int VEL_W      = 7;
  localparam int NOTE_W     = 7;
  localparam int PPH_W      = 17;
  localparam int FREQ_W     = 30;
  localparam int SINE_W     = 15;
  localparam int PROD_W     = SINE_W + LEVEL_W;
  localparam int SAMPLE_W   = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_PER_HZ = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEVEL = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP    = CFG_IDX_W'(2);

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [PPH_W-1:0]   PPH_RESET    = PPH_W'(97392);
  localparam logic [LEVEL_W-1:0] TARGET_RESET = LEVEL_W'(6554);
  localparam logic [LEVEL_W-1:0] STEP_RESET   = LEVEL_W'(33);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  typedef logic [FREQ_W-1:0] freq_tab_t [NUM_VOICES];
  typedef logic [SINE_W-1:0] sine_tab_t [SINE_TABLE_DEPTH + 1];

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_DRAIN,
    SEQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic              issue;
    logic [ADDR_W-1:0] addr;
    logic              clear;
  } seq_ctl_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [LEVEL_W-1:0] level;
    logic [VEL_W-1:0]   vel;
  } voice_rd_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [PHASE_W-1:0] phase;
    logic [LEVEL_W-1:0] level;
  } voice_wr_t;

  function automatic logic [31:0] top_octave(input int unsigned pc);
    logic [31:0] f;
    case (pc)
      0:       f = 32'd435478539;
      1:       f = 32'd461373440;
      2:       f = 32'd488808132;
      3:       f = 32'd517874176;
      4:       f = 32'd548668578;
      5:       f = 32'd581294109;
      6:       f = 32'd615859655;
      7:       f = 32'd652480576;
      8:       f = 32'd691279090;
      9:       f = 32'd732384684;
      10:      f = 32'd775934544;
      11:      f = 32'd822074013;
      default: f = 32'd0;
    endcase
    return f;
  endfunction

  function automatic freq_tab_t note_pitch_table();
    freq_tab_t   t;
    int unsigned pc;
    int unsigned oct;
    for (int n = 0; n < NUM_VOICES; n++) begin
      pc   = (n + 4) % 12;
      oct  = (127 - n) / 12;
      t[n] = FREQ_W'(top_octave(pc) >> oct);
    end
    return t;
  endfunction

  function automatic logic [SINE_W-1:0] sine_entry(input longint unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint          s;
    x    = (HALF_PI_Q30 * i) / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    s    = longint'(x);
    term = ((x * x2) >> 30) / 64'd6;
    s    = s - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    s    = s + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    s    = s - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    s    = s + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    s    = s - longint'(term);
    if (s < 0) begin
      s = 0;
    end
    if (longint'(ONE_Q30) < s) begin
      s = longint'(ONE_Q30);
    end
    r = (longint'(s) * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    return r[SINE_W-1:0];
  endfunction

  function automatic sine_tab_t sine_table();
    sine_tab_t t;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      t[i] = sine_entry(longint'(i));
    end
    return t;
  endfunction

endpackage

@@ design/psvb_voice_mem.sv @@
// Voice state store: phase and level in one memory, key velocity in another.
// Reads are registered; per-entry valid bits make unwritten entries read as zero. Uses psvb_pkg.
module psvb_voice_mem (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [psvb_pkg::ADDR_W-1:0] rd_addr,
  output psvb_pkg::voice_rd_t         rd,
  input  psvb_pkg::voice_wr_t         pl_wr,
  input  logic                        vel_we,
  input  logic [psvb_pkg::ADDR_W-1:0] vel_addr,
  input  logic [psvb_pkg::VEL_W-1:0]  vel_data
);

  logic [psvb_pkg::PHASE_W+psvb_pkg::LEVEL_W-1:0] pl_mem [psvb_pkg::NUM_VOICES];
  logic [psvb_pkg::VEL_W-1:0]                     vel_mem [psvb_pkg::NUM_VOICES];
  logic [psvb_pkg::NUM_VOICES-1:0]                pl_written;
  logic [psvb_pkg::NUM_VOICES-1:0]                vel_written;
  logic [psvb_pkg::PHASE_W+psvb_pkg::LEVEL_W-1:0] pl_q;
  logic [psvb_pkg::VEL_W-1:0]                     vel_q;
  logic                                           pl_ok;
  logic                                           vel_ok;

  always_ff @(posedge clk) begin
    if (pl_wr.en) begin
      pl_mem[pl_wr.addr] <= {pl_wr.phase, pl_wr.level};
    end
    if (vel_we) begin
      vel_mem[vel_addr] <= vel_data;
    end
    pl_q   <= pl_mem[rd_addr];
    vel_q  <= vel_mem[rd_addr];
    pl_ok  <= pl_written[rd_addr];
    vel_ok <= vel_written[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pl_written  <= '0;
      vel_written <= '0;
    end else begin
      if (pl_wr.en) begin
        pl_written[pl_wr.addr] <= 1'b1;
      end
      if (vel_we) begin
        vel_written[vel_addr] <= 1'b1;
      end
    end
  end

  assign rd.phase = pl_ok ? pl_q[psvb_pkg::LEVEL_W +: psvb_pkg::PHASE_W] : '0;
  assign rd.level = pl_ok ? pl_q[psvb_pkg::LEVEL_W-1:0] : '0;
  assign rd.vel   = vel_ok ? vel_q : '0;

endmodule

@@ design/psvb_sine_rom.sv @@
// Quarter-wave sine ROM, unsigned Q0.15 magnitudes, registered read.
// Contents are built at elaboration by psvb_pkg::sine_table.
module psvb_sine_rom (
  input  logic                            clk,
  input  logic [psvb_pkg::SINE_IDX_W-1:0] addr,
  output logic [psvb_pkg::SINE_W-1:0]     data
);

  localparam psvb_pkg::sine_tab_t ROM = psvb_pkg::sine_table();

  always_ff @(posedge clk) begin
    data <= ROM[addr];
  end

endmodule

@@ design/psvb_ctrl.sv @@
// Tick sequencer: walks the voice addresses once per tick, waits for the pipe to drain
// and hands the sum to the output register. Uses psvb_pkg.
module psvb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick,
  input  logic               pipe_empty,
  input  logic               out_free,
  output psvb_pkg::seq_ctl_t ctl,
  output logic               load_out,
  output logic               busy
);

  psvb_pkg::seq_state_t        state;
  psvb_pkg::seq_state_t        state_next;
  logic [psvb_pkg::ADDR_W-1:0] cnt;
  logic [psvb_pkg::ADDR_W-1:0] cnt_next;
  logic                        last;

  assign last = (cnt == psvb_pkg::ADDR_W'(psvb_pkg::NUM_VOICES - 1));

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      psvb_pkg::SEQ_IDLE: begin
        cnt_next = '0;
        if (tick) begin
          state_next = psvb_pkg::SEQ_RUN;
        end
      end
      psvb_pkg::SEQ_RUN: begin
        if (last) begin
          state_next = psvb_pkg::SEQ_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      psvb_pkg::SEQ_DRAIN: begin
        if (pipe_empty) begin
          state_next = psvb_pkg::SEQ_DONE;
        end
      end
      psvb_pkg::SEQ_DONE: begin
        if (out_free) begin
          state_next = psvb_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_next = psvb_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl.issue = 1'b0;
    ctl.addr  = cnt;
    ctl.clear = 1'b0;
    load_out  = 1'b0;
    busy      = 1'b1;
    case (state)
      psvb_pkg::SEQ_IDLE: begin
        busy      = 1'b0;
        ctl.clear = tick;
      end
      psvb_pkg::SEQ_RUN: begin
        ctl.issue = 1'b1;
      end
      psvb_pkg::SEQ_DRAIN: begin
      end
      psvb_pkg::SEQ_DONE: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psvb_pkg::SEQ_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

@@ design/psvb_voice_pipe.sv @@
// Per-voice pipeline: level ramp, tuning word, sine lookup, scaling and accumulation.
// Reads voice state from psvb_voice_mem, writes it back; holds psvb_sine_rom. Uses psvb_pkg.
module psvb_voice_pipe (
  input  logic                          clk,
  input  logic                          rst,
  input  psvb_pkg::seq_ctl_t            ctl,
  input  psvb_pkg::voice_rd_t           rd,
  input  logic [psvb_pkg::PPH_W-1:0]    phase_per_hz,
  input  logic [psvb_pkg::LEVEL_W-1:0]  target_level,
  input  logic [psvb_pkg::LEVEL_W-1:0]  ramp_step,
  output psvb_pkg::voice_wr_t           wr,
  output logic [psvb_pkg::SAMPLE_W-1:0] acc,
  output logic                          empty
);

  localparam int TW_W  = psvb_pkg::FREQ_W + psvb_pkg::PPH_W;
  localparam int IDX_P = 30 + psvb_pkg::SINE_IDX_W;
  localparam psvb_pkg::freq_tab_t FREQ_TAB = psvb_pkg::note_pitch_table();

  logic                            a_v;
  logic [psvb_pkg::ADDR_W-1:0]     a_addr;
  logic [psvb_pkg::FREQ_W-1:0]     a_freq;

  logic [psvb_pkg::LEVEL_W-1:0]    tgt;
  logic [psvb_pkg::LEVEL_W:0]      up_sum;
  logic [psvb_pkg::LEVEL_W-1:0]    up;
  logic [IDX_P-1:0]                idx_prod;
  logic [psvb_pkg::SINE_IDX_W-1:0] idx_raw;
  logic [psvb_pkg::SINE_IDX_W-1:0] idx;

  logic                            b_v;
  logic [psvb_pkg::ADDR_W-1:0]     b_addr;
  logic [psvb_pkg::PHASE_W-1:0]    b_phase;
  logic [psvb_pkg::LEVEL_W-1:0]    b_up;
  logic [psvb_pkg::LEVEL_W-1:0]    b_tgt;
  logic [psvb_pkg::SINE_IDX_W-1:0] b_idx;
  logic                            b_neg;
  logic [TW_W-1:0]                 b_tw;

  logic [psvb_pkg::LEVEL_W-1:0]    lvl_new;

  logic                            c_v;
  logic [psvb_pkg::LEVEL_W-1:0]    c_level;
  logic                            c_neg;
  logic [psvb_pkg::SINE_W-1:0]     c_sine;

  logic                            d_v;
  logic                            d_neg;
  logic [psvb_pkg::PROD_W-1:0]     d_prod;
  logic [psvb_pkg::SAMPLE_W-1:0]   mag;

  // stage B: ramp up, sine index
  assign tgt    = (rd.vel != '0) ? target_level : '0;
  assign up_sum = {1'b0, rd.level} + {1'b0, ramp_step};
  assign up     = (rd.level < tgt) ?
                  (up_sum[psvb_pkg::LEVEL_W] ? '1 : up_sum[psvb_pkg::LEVEL_W-1:0]) : rd.level;

  assign idx_prod = IDX_P'(rd.phase[29:0]) * IDX_P'(psvb_pkg::SINE_TABLE_DEPTH);
  assign idx_raw  = idx_prod[30 +: psvb_pkg::SINE_IDX_W];
  assign idx      = rd.phase[30] ?
                    psvb_pkg::SINE_IDX_W'(psvb_pkg::SINE_TABLE_DEPTH) - idx_raw : idx_raw;

  // stage C: ramp down, advance phase, write back
  assign lvl_new = (b_up > b_tgt) ? ((b_up >= ramp_step) ? b_up - ramp_step : '0) : b_up;

  assign wr.en    = b_v;
  assign wr.addr  = b_addr;
  assign wr.level = lvl_new;
  assign wr.phase = b_phase + psvb_pkg::PHASE_W'(b_tw >> 16);

  assign mag = psvb_pkg::SAMPLE_W'(d_prod >> 16);

  psvb_sine_rom u_rom (
    .clk  (clk),
    .addr (b_idx),
    .data (c_sine)
  );

  always_ff @(posedge clk) begin
    a_addr  <= ctl.addr;
    a_freq  <= FREQ_TAB[ctl.addr];
    b_addr  <= a_addr;
    b_phase <= rd.phase;
    b_up    <= up;
    b_tgt   <= tgt;
    b_idx   <= idx;
    b_neg   <= rd.phase[31];
    b_tw    <= TW_W'(a_freq) * TW_W'(phase_per_hz);
    c_level <= lvl_new;
    c_neg   <= b_neg;
    d_neg   <= c_neg;
    d_prod  <= psvb_pkg::PROD_W'(c_sine) * psvb_pkg::PROD_W'(c_level);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      acc <= '0;
    end else begin
      a_v <= ctl.issue;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      if (ctl.clear) begin
        acc <= '0;
      end else if (d_v) begin
        acc <= d_neg ? acc - mag : acc + mag;
      end
    end
  end

  assign empty = !(a_v || b_v || c_v || d_v);

endmodule

@@ design/polyphonic_sine_voice_bank.sv @@
// Sine voice bank top level. A key word completes in its accept cycle, no result.
// A tick word walks the 128 voices, one voice read per cycle from the voice memory
// read port, through 4 pipeline stages; the sequencer then waits for the pipe to empty
// and hands the sum to the sample register before it takes the next word.
// A waiting sample does not block acceptance of the next word, but the next hand-off waits for it to be taken.
// Synchronous reset restores register defaults and marks all voice entries as zero.
module polyphonic_sine_voice_bank (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 command,
  input  logic [psvb_pkg::NOTE_W-1:0]          note,
  input  logic [psvb_pkg::VEL_W-1:0]           velocity,
  output logic                                 sample_valid,
  input  logic                                 sample_stall,
  output logic signed [psvb_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [psvb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psvb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [psvb_pkg::PPH_W-1:0]    phase_per_hz;
  logic [psvb_pkg::LEVEL_W-1:0]  target_level;
  logic [psvb_pkg::LEVEL_W-1:0]  ramp_step;

  logic                          item_acc;
  logic                          key;
  logic                          tick;
  logic                          note_ok;
  logic                          key_clear;
  logic                          busy;
  logic                          load_out;
  logic                          out_free;
  logic                          pipe_empty;
  logic [psvb_pkg::SAMPLE_W-1:0] acc;
  psvb_pkg::seq_ctl_t            ctl;
  psvb_pkg::voice_rd_t           rd;
  psvb_pkg::voice_wr_t           pipe_wr;
  psvb_pkg::voice_wr_t           mem_wr;

  assign cfg_ready  = 1'b1;
  assign item_stall = busy;
  assign item_acc   = item_valid && !item_stall;
  assign key        = item_acc && (command == psvb_pkg::CMD_KEY);
  assign tick       = item_acc && (command == psvb_pkg::CMD_TICK);
  assign note_ok    = ({1'b0, note} < (psvb_pkg::NOTE_W + 1)'(psvb_pkg::NUM_VOICES));
  assign key_clear  = key && note_ok && (velocity != '0);
  assign out_free   = !sample_valid || !sample_stall;

  always_comb begin
    mem_wr = pipe_wr;
    if (key_clear) begin
      mem_wr.en    = 1'b1;
      mem_wr.addr  = note[psvb_pkg::ADDR_W-1:0];
      mem_wr.phase = '0;
      mem_wr.level = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_per_hz <= psvb_pkg::PPH_RESET;
      target_level <= psvb_pkg::TARGET_RESET;
      ramp_step    <= psvb_pkg::STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psvb_pkg::CFG_PHASE_PER_HZ: phase_per_hz <= cfg_data;
        psvb_pkg::CFG_TARGET_LEVEL: target_level <= cfg_data[psvb_pkg::LEVEL_W-1:0];
        psvb_pkg::CFG_RAMP_STEP:    ramp_step    <= cfg_data[psvb_pkg::LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  psvb_voice_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (ctl.addr),
    .rd       (rd),
    .pl_wr    (mem_wr),
    .vel_we   (key && note_ok),
    .vel_addr (note[psvb_pkg::ADDR_W-1:0]),
    .vel_data (velocity)
  );

  psvb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .pipe_empty (pipe_empty),
    .out_free   (out_free),
    .ctl        (ctl),
    .load_out   (load_out),
    .busy       (busy)
  );

  psvb_voice_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .rd           (rd),
    .phase_per_hz (phase_per_hz),
    .target_level (target_level),
    .ramp_step    (ramp_step),
    .wr           (pipe_wr),
    .acc          (acc),
    .empty        (pipe_empty)
  );

  always_ff @(posedge clk) begin
    if (load_out) begin
      sample <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (load_out) begin
      sample_valid <= 1'b1;
    end else if (!sample_stall) begin
      sample_valid <= 1'b0;
    end
  end

endmodule

@@ design/psvb_checker.sv @@
// Port-level checks for the sine voice bank, bound to the top level.
// Uses psvb_pkg for the command codes.
module psvb_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 item_valid,
  input logic                                 item_stall,
  input logic                                 command,
  input logic                                 sample_valid,
  input logic                                 sample_stall,
  input logic signed [psvb_pkg::SAMPLE_W-1:0] sample
);

  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (command == psvb_pkg::CMD_KEY) |=> !item_stall)
    else $error("key word must not hold off the next word");

  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (command == psvb_pkg::CMD_TICK) |=> item_stall)
    else $error("tick word must hold off input while voices are walked");

  assert property (@(posedge clk) disable iff (rst)
    $rose(sample_valid) |-> $past(item_stall))
    else $error("sample appeared without a tick in progress");

  assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_stall |=> sample_valid && $stable(sample))
    else $error("stalled sample dropped or changed");

endmodule

bind polyphonic_sine_voice_bank psvb_checker u_psvb_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .command      (command),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .sample       (sample)
);
